[rtl/axis_angle_point_rotation_unit_assert.svh]
`ifndef AXIS_ANGLE_POINT_ROTATION_UNIT_ASSERT_SVH
`define AXIS_ANGLE_POINT_ROTATION_UNIT_ASSERT_SVH

// cond must hold in the same cycle as trig
`define AAPR_ASSERT_IMPLIES(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// cond must hold in the cycle after trig
`define AAPR_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

[rtl/aapr_pkg.sv]
package aapr_pkg;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} vec3_t;

	// angle in Q9.6 degrees: one turn is 360 * 64 codes
	localparam int TURN_UNITS = 23040;
	localparam int HALF_TURN_UNITS = 11520;
	localparam int TURN_W = 15;
	// 23040 = 45 << 9, so divide by 512 first and then by 45
	localparam int PRE_SHIFT = 9;
	localparam int RECIP_W = 27;
	localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443718;
	localparam int RECIP_SHIFT = 32;

	// pi/2 in Q30, Taylor divisors (2n)(2n+1) for the sine series
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam int TAYLOR_TERMS = 7;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

	localparam int WIDE_W = 72;
	localparam logic signed [WIDE_W-1:0] WIDE_MAX = 72'sd32767;
	localparam logic signed [WIDE_W-1:0] WIDE_MIN = -72'sd32768;

	// width of a signed matrix element for f fraction bits
	function automatic int elem_width(input int f);
		int a;
		a = 32 - f;
		if (a < 16) begin
			a = 16;
		end
		if (f + 1 > a) begin
			a = f + 1;
		end
		return a + 2;
	endfunction

	// round to nearest, ties away from zero
	function automatic logic signed [WIDE_W-1:0] round_shift(
		input logic signed [WIDE_W-1:0] v,
		input int sh
	);
		logic signed [WIDE_W-1:0] half;
		logic signed [WIDE_W-1:0] neg;
		half = {{(WIDE_W-1){1'b0}}, 1'b1} << (sh - 1);
		neg = {{(WIDE_W-1){1'b0}}, v[WIDE_W-1]};
		return (v + half - neg) >>> sh;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] t;
		t = v;
		if (v > WIDE_MAX) begin
			t = WIDE_MAX;
		end else if (v < WIDE_MIN) begin
			t = WIDE_MIN;
		end
		return t[15:0];
	endfunction

endpackage

[rtl/aapr_in_if.sv]
interface aapr_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] axis_u;
	logic signed [15:0] axis_v;
	logic signed [15:0] axis_w;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic signed [15:0] point_z;
	logic signed [15:0] angle_deg;

	modport source (
		output valid, axis_u, axis_v, axis_w, point_x, point_y, point_z, angle_deg,
		input ready
	);
	modport sink (
		input valid, axis_u, axis_v, axis_w, point_x, point_y, point_z, angle_deg,
		output ready
	);
endinterface

[rtl/aapr_out_if.sv]
interface aapr_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] rotated_x;
	logic signed [15:0] rotated_y;
	logic signed [15:0] rotated_z;

	modport source (
		output valid, rotated_x, rotated_y, rotated_z,
		input ready
	);
	modport sink (
		input valid, rotated_x, rotated_y, rotated_z,
		output ready
	);
endinterface

[rtl/aapr_sine_rom.sv]
module aapr_sine_rom #(
	parameter int COORD_FRAC_BITS = 14,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input logic clk,
	input logic en,
	input logic [$clog2(SINE_TABLE_DEPTH):0] addr_a,
	input logic [$clog2(SINE_TABLE_DEPTH):0] addr_b,
	output logic [COORD_FRAC_BITS:0] data_a,
	output logic [COORD_FRAC_BITS:0] data_b
);

	typedef logic [COORD_FRAC_BITS:0] entry_t;
	typedef entry_t rom_t [SINE_TABLE_DEPTH+1];

	// sin(k*pi/(2D)) by Taylor series in Q30, then rounded to Q(F) and clamped
	function automatic entry_t quarter_sine(input longint unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint v;
		longint one;
		longint half;
		int n;
		int sh;
		x = (k * aapr_pkg::HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		sum = longint'(x);
		one = longint'(1) << COORD_FRAC_BITS;
		for (n = 0; n < aapr_pkg::TAYLOR_TERMS; n++) begin
			term = (term * x2 + (64'd1 << 29)) >> 30;
			term = (term + aapr_pkg::TAYLOR_DIV[n] / 2) / aapr_pkg::TAYLOR_DIV[n];
			if (!n[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		sh = 30 - COORD_FRAC_BITS;
		v = sum;
		if (sh > 0) begin
			half = longint'(1) << (sh - 1);
			if (sum >= 0) begin
				v = (sum + half) >>> sh;
			end else begin
				v = -((half - sum) >>> sh);
			end
		end
		if (v < 0) begin
			v = 0;
		end
		if (v > one) begin
			v = one;
		end
		return entry_t'(v);
	endfunction

	function automatic rom_t build_rom();
		rom_t t;
		int k;
		for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			t[k] = quarter_sine(64'(k));
		end
		t[0] = '0;
		t[SINE_TABLE_DEPTH] = entry_t'(longint'(1) << COORD_FRAC_BITS);
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	entry_t data_a_q;
	entry_t data_b_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_a_q <= SINE_ROM[addr_a];
			data_b_q <= SINE_ROM[addr_b];
		end
	end

	assign data_a = data_a_q;
	assign data_b = data_b_q;

endmodule

[rtl/aapr_angle.sv]
`include "axis_angle_point_rotation_unit_assert.svh"

module aapr_angle #(
	parameter int COORD_FRAC_BITS = 14,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [15:0] angle_deg,
	input aapr_pkg::vec3_t axis_in,
	input aapr_pkg::vec3_t point_in,
	output logic out_valid,
	input logic out_ready,
	output aapr_pkg::vec3_t axis_out,
	output aapr_pkg::vec3_t point_out,
	output logic signed [COORD_FRAC_BITS+1:0] sin_out,
	output logic signed [COORD_FRAC_BITS+1:0] cos_out
);

	localparam int LD = $clog2(SINE_TABLE_DEPTH);
	localparam int PH_W = LD + 2;
	localparam int ADDR_W = LD + 1;
	localparam int TRIG_W = COORD_FRAC_BITS + 2;
	localparam int N_W = aapr_pkg::TURN_W + PH_W + 1;
	localparam int M_W = N_W - aapr_pkg::PRE_SHIFT;
	localparam int PROD_W = M_W + aapr_pkg::RECIP_W;
	localparam logic signed [16:0] TURN_S = 17'sd23040;
	localparam logic signed [16:0] TWO_TURN_S = 17'sd46080;
	localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(SINE_TABLE_DEPTH);

	logic en1, en2, en3;
	logic v_s1, v_s2, v_s3;
	logic [aapr_pkg::TURN_W-1:0] r_s1;
	logic [PROD_W-1:0] prod_s2;
	logic neg_s_s3, neg_c_s3;
	aapr_pkg::vec3_t axis_s1, axis_s2, axis_s3;
	aapr_pkg::vec3_t point_s1, point_s2, point_s3;

	logic signed [16:0] a_ext;
	logic signed [16:0] r_wide;
	logic [N_W-1:0] num;
	logic [M_W-1:0] m_val;
	logic [PROD_W-1:0] prod_next;
	logic [PH_W-1:0] phase;
	logic [1:0] quad_s, quad_c;
	logic [LD-1:0] k_idx;
	logic [ADDR_W-1:0] addr_s, addr_c;
	logic [COORD_FRAC_BITS:0] tab_s, tab_c;
	logic signed [TRIG_W-1:0] sin_mag, cos_mag;

	// stage-advance chain, a bubble in any stage is squeezed out
	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	// angle mod one turn by compare and add or subtract
	always_comb begin
		a_ext = 17'(angle_deg);
		if (a_ext < -TURN_S) begin
			r_wide = a_ext + TWO_TURN_S;
		end else if (a_ext < 17'sd0) begin
			r_wide = a_ext + TURN_S;
		end else if (a_ext >= TURN_S) begin
			r_wide = a_ext - TURN_S;
		end else begin
			r_wide = a_ext;
		end
	end

	// phase = round(r * 4D / 23040), the divide by 45 is a reciprocal multiply
	assign num = (N_W'(r_s1) << PH_W) + N_W'(aapr_pkg::HALF_TURN_UNITS);
	assign m_val = num[N_W-1:aapr_pkg::PRE_SHIFT];
	assign prod_next = PROD_W'(m_val) * PROD_W'(aapr_pkg::RECIP_45);

	// quadrant folding, cos is a quarter turn ahead
	assign phase = prod_s2[aapr_pkg::RECIP_SHIFT +: PH_W];
	assign quad_s = phase[PH_W-1 -: 2];
	assign quad_c = quad_s + 2'd1;
	assign k_idx = phase[LD-1:0];
	assign addr_s = quad_s[0] ? DEPTH_A - {1'b0, k_idx} : {1'b0, k_idx};
	assign addr_c = quad_c[0] ? DEPTH_A - {1'b0, k_idx} : {1'b0, k_idx};

	aapr_sine_rom #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk (clk),
		.en (en3),
		.addr_a (addr_s),
		.addr_b (addr_c),
		.data_a (tab_s),
		.data_b (tab_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1 <= r_wide[aapr_pkg::TURN_W-1:0];
			axis_s1 <= axis_in;
			point_s1 <= point_in;
		end
		if (en2) begin
			prod_s2 <= prod_next;
			axis_s2 <= axis_s1;
			point_s2 <= point_s1;
		end
		if (en3) begin
			neg_s_s3 <= quad_s[1];
			neg_c_s3 <= quad_c[1];
			axis_s3 <= axis_s2;
			point_s3 <= point_s2;
		end
	end

	assign sin_mag = {1'b0, tab_s};
	assign cos_mag = {1'b0, tab_c};
	assign sin_out = neg_s_s3 ? -sin_mag : sin_mag;
	assign cos_out = neg_c_s3 ? -cos_mag : cos_mag;
	assign out_valid = v_s3;
	assign axis_out = axis_s3;
	assign point_out = point_s3;

	`AAPR_ASSERT_IMPLIES(a_turn_reduced, clk, arst_n, v_s1,
		r_s1 < aapr_pkg::TURN_W'(aapr_pkg::TURN_UNITS), "reduced angle not below one turn")
	`AAPR_ASSERT_IMPLIES(a_rom_addr_range, clk, arst_n, v_s2,
		(addr_s <= DEPTH_A) && (addr_c <= DEPTH_A), "sine table address past quarter wave")

endmodule

[rtl/aapr_matrix.sv]
`include "axis_angle_point_rotation_unit_assert.svh"

module aapr_matrix #(
	parameter int COORD_FRAC_BITS = 14,
	localparam int EW = aapr_pkg::elem_width(COORD_FRAC_BITS)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input aapr_pkg::vec3_t axis_in,
	input aapr_pkg::vec3_t point_in,
	input logic signed [COORD_FRAC_BITS+1:0] sin_in,
	input logic signed [COORD_FRAC_BITS+1:0] cos_in,
	output logic out_valid,
	input logic out_ready,
	output aapr_pkg::vec3_t point_out,
	output logic [8:0][EW-1:0] elem
);

	localparam int F = COORD_FRAC_BITS;
	localparam int TRIG_W = F + 2;
	localparam int CC_W = F + 3;
	localparam int SQ_W = 32;
	localparam int SP_W = 16 + TRIG_W;
	localparam int CCP_W = SQ_W + CC_W;
	localparam int WW = aapr_pkg::WIDE_W;
	localparam logic signed [CC_W-1:0] ONE_CC = {2'b00, 1'b1, {F{1'b0}}};
	localparam logic signed [CC_W-1:0] TWO_CC = {1'b0, 1'b1, {(F+1){1'b0}}};

	logic en4, en5, en6;
	logic v_s4, v_s5, v_s6;

	// axis products: uu, vv, ww, uv, uw, vw
	logic signed [SQ_W-1:0] sq_s4 [6];
	// axis times sine: us, vs, ws
	logic signed [SP_W-1:0] sp_s4 [3];
	logic signed [CC_W-1:0] cc_s4;
	logic signed [TRIG_W-1:0] c_s4, c_s5;
	logic signed [CCP_W-1:0] ccp_s5 [6];
	logic signed [EW-1:0] sn_s5 [3];
	logic [8:0][EW-1:0] elem_s6;
	aapr_pkg::vec3_t point_s4, point_s5, point_s6;

	logic signed [CC_W-1:0] cc_next;
	logic signed [WW-1:0] sp_round [3];
	logic signed [WW-1:0] sq_round [6];
	logic signed [EW-1:0] sq_e [6];
	logic signed [EW-1:0] c_e;
	logic [8:0][EW-1:0] elem_next;

	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign in_ready = en4;

	assign cc_next = ONE_CC - CC_W'(cos_in);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sp_round[i] = aapr_pkg::round_shift(WW'(sp_s4[i]), F);
		end
		for (int i = 0; i < 6; i++) begin
			sq_round[i] = aapr_pkg::round_shift(WW'(ccp_s5[i]), 2 * F);
			sq_e[i] = sq_round[i][EW-1:0];
		end
	end

	// element sums, rows of the rotation matrix
	always_comb begin
		c_e = EW'(c_s5);
		elem_next[0] = sq_e[0] + c_e;
		elem_next[1] = sq_e[3] - sn_s5[2];
		elem_next[2] = sq_e[4] + sn_s5[1];
		elem_next[3] = sq_e[3] + sn_s5[2];
		elem_next[4] = sq_e[1] + c_e;
		elem_next[5] = sq_e[5] - sn_s5[0];
		elem_next[6] = sq_e[4] - sn_s5[1];
		elem_next[7] = sq_e[5] + sn_s5[0];
		elem_next[8] = sq_e[2] + c_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en4) begin
				v_s4 <= in_valid;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
			if (en6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			sq_s4[0] <= axis_in.x * axis_in.x;
			sq_s4[1] <= axis_in.y * axis_in.y;
			sq_s4[2] <= axis_in.z * axis_in.z;
			sq_s4[3] <= axis_in.x * axis_in.y;
			sq_s4[4] <= axis_in.x * axis_in.z;
			sq_s4[5] <= axis_in.y * axis_in.z;
			sp_s4[0] <= SP_W'(axis_in.x) * SP_W'(sin_in);
			sp_s4[1] <= SP_W'(axis_in.y) * SP_W'(sin_in);
			sp_s4[2] <= SP_W'(axis_in.z) * SP_W'(sin_in);
			cc_s4 <= cc_next;
			c_s4 <= cos_in;
			point_s4 <= point_in;
		end
		if (en5) begin
			for (int i = 0; i < 6; i++) begin
				ccp_s5[i] <= CCP_W'(sq_s4[i]) * CCP_W'(cc_s4);
			end
			for (int i = 0; i < 3; i++) begin
				sn_s5[i] <= sp_round[i][EW-1:0];
			end
			c_s5 <= c_s4;
			point_s5 <= point_s4;
		end
		if (en6) begin
			elem_s6 <= elem_next;
			point_s6 <= point_s5;
		end
	end

	assign out_valid = v_s6;
	assign point_out = point_s6;
	assign elem = elem_s6;

	`AAPR_ASSERT_IMPLIES(a_one_minus_cos, clk, arst_n, v_s4,
		(cc_s4 >= '0) && (cc_s4 <= TWO_CC), "one minus cosine out of range")
	`AAPR_ASSERT_NEXT(a_capture, clk, arst_n, in_valid && in_ready, v_s4,
		"accepted beat not captured in first matrix stage")

endmodule

[rtl/aapr_apply.sv]
module aapr_apply #(
	parameter int COORD_FRAC_BITS = 14,
	localparam int EW = aapr_pkg::elem_width(COORD_FRAC_BITS)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input aapr_pkg::vec3_t point_in,
	input logic [8:0][EW-1:0] elem,
	output logic out_valid,
	input logic out_ready,
	output aapr_pkg::vec3_t rotated
);

	localparam int PR_W = 16 + EW;
	localparam int SUM_W = PR_W + 2;
	localparam int WW = aapr_pkg::WIDE_W;

	logic en7, en8;
	logic v_s7, v_s8;
	logic signed [PR_W-1:0] prod_s7 [9];
	logic signed [15:0] rot_s8 [3];

	logic signed [15:0] pt [3];
	logic signed [SUM_W-1:0] row_sum [3];
	logic signed [15:0] rot_next [3];

	assign en8 = !v_s8 || out_ready;
	assign en7 = !v_s7 || en8;
	assign in_ready = en7;

	assign pt[0] = point_in.x;
	assign pt[1] = point_in.y;
	assign pt[2] = point_in.z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_sum[i] = SUM_W'(prod_s7[3*i]) + SUM_W'(prod_s7[3*i+1])
				+ SUM_W'(prod_s7[3*i+2]);
			rot_next[i] = aapr_pkg::sat16(
				aapr_pkg::round_shift(WW'(row_sum[i]), COORD_FRAC_BITS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en7) begin
				v_s7 <= in_valid;
			end
			if (en8) begin
				v_s8 <= v_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s7[3*i+j] <= PR_W'(pt[j]) * PR_W'($signed(elem[3*i+j]));
				end
			end
		end
		if (en8) begin
			for (int i = 0; i < 3; i++) begin
				rot_s8[i] <= rot_next[i];
			end
		end
	end

	assign out_valid = v_s8;
	assign rotated.x = rot_s8[0];
	assign rotated.y = rot_s8[1];
	assign rotated.z = rot_s8[2];

endmodule

[rtl/axis_angle_point_rotation_unit.sv]
// Rotates a point about a unit axis by an angle in degrees (axis-angle, Rodrigues
// matrix). One beat in carries axis, point and angle; one beat out carries the
// rotated point, in order. Coordinates are signed 16-bit codes with
// COORD_FRAC_BITS fraction bits, the angle is Q9.6 degrees and is taken modulo 360.
// The axis is used as given, never normalized; each result component saturates.
// Throughput is one beat per clock while results are taken. An accepted input
// beat reaches the output through the eight register stages, in order: angle
// reduction, reciprocal multiply for the phase, sine table read, axis products,
// products with (1 - cos), matrix element sums, point-by-element products, and
// row sum with rounding and saturation. Each stage advances when it is empty or
// the stage after it moves, so bubbles close up and a stalled result does not
// block input until all eight stages hold beats. The quarter-wave sine table
// (SINE_TABLE_DEPTH + 1 entries) is a constant table with two registered read
// ports, one for sine and one for cosine. SINE_TABLE_DEPTH must be a power of two.
// No clearing pass after reset: the block takes beats from the first cycle.
`include "axis_angle_point_rotation_unit_assert.svh"

module axis_angle_point_rotation_unit #(
	parameter int COORD_FRAC_BITS = 14,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	aapr_in_if.sink sample,
	aapr_out_if.source result
);

	localparam int EW = aapr_pkg::elem_width(COORD_FRAC_BITS);

	// packed views of the input beat
	aapr_pkg::vec3_t axis_in;
	aapr_pkg::vec3_t point_in;

	// angle section to matrix section
	logic a_valid;
	logic a_ready;
	aapr_pkg::vec3_t axis_a;
	aapr_pkg::vec3_t point_a;
	logic signed [COORD_FRAC_BITS+1:0] sin_a;
	logic signed [COORD_FRAC_BITS+1:0] cos_a;

	// matrix section to point transform
	logic m_valid;
	logic m_ready;
	aapr_pkg::vec3_t point_m;
	logic [8:0][EW-1:0] elem_m;

	aapr_pkg::vec3_t rot;

	assign axis_in.x = sample.axis_u;
	assign axis_in.y = sample.axis_v;
	assign axis_in.z = sample.axis_w;
	assign point_in.x = sample.point_x;
	assign point_in.y = sample.point_y;
	assign point_in.z = sample.point_z;

	// stages 1-3: angle to phase, sine and cosine lookup
	aapr_angle #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_angle (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.angle_deg (sample.angle_deg),
		.axis_in (axis_in),
		.point_in (point_in),
		.out_valid (a_valid),
		.out_ready (a_ready),
		.axis_out (axis_a),
		.point_out (point_a),
		.sin_out (sin_a),
		.cos_out (cos_a)
	);

	// stages 4-6: rotation matrix elements
	aapr_matrix #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_matrix (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (a_valid),
		.in_ready (a_ready),
		.axis_in (axis_a),
		.point_in (point_a),
		.sin_in (sin_a),
		.cos_in (cos_a),
		.out_valid (m_valid),
		.out_ready (m_ready),
		.point_out (point_m),
		.elem (elem_m)
	);

	// stages 7-8: matrix times point, round, saturate; stage 8 is the output register
	aapr_apply #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_apply (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (m_valid),
		.in_ready (m_ready),
		.point_in (point_m),
		.elem (elem_m),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.rotated (rot)
	);

	assign result.rotated_x = rot.x;
	assign result.rotated_y = rot.y;
	assign result.rotated_z = rot.z;

	// with no result pending every stage can advance, so input must be open
	`AAPR_ASSERT_IMPLIES(a_ready_when_drained, clk, arst_n, !result.valid, sample.ready,
		"input stalled while no result is pending")

endmodule
